// ===== design/tlv_pkg.sv =====
// ----------------------------------------------------------------------------
// tlv_pkg
// Shared widths, character codes and register map of the line validator.
// ----------------------------------------------------------------------------
package tlv_pkg;

  localparam int LINE_BUFFER_BYTES_DEF = 64;

  localparam int BYTE_W   = 8;
  localparam int SEPX_W   = 6;
  localparam int OFFSET_W = 6;
  localparam int LENGTH_W = 7;
  localparam int SEPCNT_W = 7;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [0:0] REG_EXPECTED_SEP = 1'b0;

  localparam logic [SEPX_W-1:0] EXPECTED_SEP_RESET = 6'd3;

  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_HIGH   = 8'h80;
  localparam logic [BYTE_W-1:0] CHAR_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CHAR_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  function automatic logic is_ctrl_or_space(input logic [BYTE_W-1:0] b);
    return (b <= CHAR_SPACE) || (b >= CHAR_HIGH);
  endfunction

  function automatic logic is_allowed(input logic [BYTE_W-1:0] b);
    return ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) || (b == CHAR_SEMI) ||
           (b == CHAR_DOT) || (b == CHAR_MINUS);
  endfunction

endpackage

// ===== design/tlv_byte_if.sv =====
// ----------------------------------------------------------------------------
// tlv_byte_if
// Valid/ready channel carrying one received serial byte per beat.
// ----------------------------------------------------------------------------
interface tlv_byte_if import tlv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/tlv_line_if.sv =====
// ----------------------------------------------------------------------------
// tlv_line_if
// Valid/ready channel carrying one line verdict per beat.
// ----------------------------------------------------------------------------
interface tlv_line_if import tlv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                line_ok;
  logic [OFFSET_W-1:0] start_offset;
  logic [LENGTH_W-1:0] trimmed_length;
  logic [SEPCNT_W-1:0] separator_count;

  modport source (output valid, output line_ok, output start_offset,
                  output trimmed_length, output separator_count, input ready);
  modport sink   (input valid, input line_ok, input start_offset,
                  input trimmed_length, input separator_count, output ready);
endinterface

// ===== design/tlv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tlv_cfg_regs
// APB-style register file holding the required separator count.
// ----------------------------------------------------------------------------
module tlv_cfg_regs import tlv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SEPX_W-1:0]     expected_separators
);

  logic [0:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[CFG_ADDR_W-1 -: 1];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready && (reg_index == REG_EXPECTED_SEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_separators <= EXPECTED_SEP_RESET;
    end else if (wr_en) begin
      expected_separators <= pwdata[SEPX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_EXPECTED_SEP) begin
      prdata = CFG_DATA_W'(expected_separators);
    end
  end

endmodule

// ===== design/tlv_line_tracker.sv =====
// ----------------------------------------------------------------------------
// tlv_line_tracker
// Running trim and validity state per byte, with the line verdict register.
// ----------------------------------------------------------------------------
module tlv_line_tracker import tlv_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SEPX_W-1:0] expected_separators,
  tlv_byte_if.sink          rx,
  tlv_line_if.source        line
);

  localparam int POS_W = $clog2(LINE_BUFFER_BYTES + 1);
  localparam int IDX_W = $clog2(LINE_BUFFER_BYTES);
  localparam int CW    = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;
  localparam logic [POS_W-1:0] LINE_MAX = POS_W'(LINE_BUFFER_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             start_seen, start_seen_next;
  logic [IDX_W-1:0] start_index, start_index_next;
  logic [POS_W-1:0] kept_end, kept_end_next;
  logic             pending_tail, pending_tail_next;
  logic [POS_W-1:0] sep_total, sep_total_next;
  logic             bad_char_seen, bad_char_seen_next;

  logic [BYTE_W-1:0] b;
  logic              accept, line_end, nonempty;
  logic [CW-1:0]     len_w, off_w, sep_w;

  assign b        = rx.rx_byte;
  assign rx.ready = !line.valid || line.ready;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    start_seen_next    = start_seen || !(is_ctrl_or_space(b) || (b == CHAR_LT));
    start_index_next   = start_seen ? start_index : byte_position[IDX_W-1:0];
    kept_end_next      = start_seen ? kept_end : byte_position;
    pending_tail_next  = start_seen ? pending_tail : 1'b0;
    sep_total_next     = sep_total;
    bad_char_seen_next = bad_char_seen;
    if (start_seen_next) begin
      if (is_ctrl_or_space(b) || (b == CHAR_GT)) begin
        pending_tail_next = 1'b1;
      end else begin
        // trailing bytes followed by a kept byte are interior and invalid
        bad_char_seen_next = bad_char_seen || pending_tail_next || !is_allowed(b);
        if (b == CHAR_SEMI) begin
          sep_total_next = sep_total + 1'b1;
        end
        kept_end_next     = byte_position + 1'b1;
        pending_tail_next = 1'b0;
      end
    end
    byte_position_next = byte_position + 1'b1;
    line_end = (byte_position_next >= LINE_MAX) || (b == CHAR_LF) || (b == CHAR_CR);

    nonempty = start_seen_next && (kept_end_next > POS_W'(start_index_next));
    len_w    = nonempty ? CW'(kept_end_next - POS_W'(start_index_next)) : '0;
    off_w    = nonempty ? CW'(start_index_next) : '0;
    sep_w    = nonempty ? CW'(sep_total_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      start_seen    <= 1'b0;
      start_index   <= '0;
      kept_end      <= '0;
      pending_tail  <= 1'b0;
      sep_total     <= '0;
      bad_char_seen <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        byte_position <= '0;
        start_seen    <= 1'b0;
        start_index   <= '0;
        kept_end      <= '0;
        pending_tail  <= 1'b0;
        sep_total     <= '0;
        bad_char_seen <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        start_seen    <= start_seen_next;
        start_index   <= start_index_next;
        kept_end      <= kept_end_next;
        pending_tail  <= pending_tail_next;
        sep_total     <= sep_total_next;
        bad_char_seen <= bad_char_seen_next;
      end
    end
  end

  // result register: load at a line end, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      line.valid <= 1'b0;
    end else begin
      line.valid <= (accept && line_end) || (line.valid && !line.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && line_end) begin
      line.line_ok         <= nonempty && !bad_char_seen_next &&
                              (CW'(sep_total_next) == CW'(expected_separators));
      line.start_offset    <= off_w[OFFSET_W-1:0];
      line.trimmed_length  <= len_w[LENGTH_W-1:0];
      line.separator_count <= sep_w[SEPCNT_W-1:0];
    end
  end

endmodule

// ===== design/telemetry_line_validator_top.sv =====
// ----------------------------------------------------------------------------
// telemetry_line_validator_top
// Frames received bytes into lines and judges each line as it ends.
// ----------------------------------------------------------------------------
// Usage:
//   rx    - one received byte per beat. A line ends on CR, LF or when
//           LINE_BUFFER_BYTES bytes have been taken; the ending byte belongs
//           to the line.
//   line  - one verdict beat per line end: line_ok, start_offset,
//           trimmed_length, separator_count. Bytes that do not end a line
//           produce no beat.
//   APB   - register 0 at address 0: expected_separators (reset 3). Write
//           only while no byte is in flight.
// Throughput is one byte per cycle while rx is ready: the trim and validity
// registers update with a few byte compares and one counter add per beat.
// The verdict is registered and appears in the cycle after the line-ending byte beat.
// The verdict register holds while the receiver stalls; rx is ready while
// the register is empty or being taken, so a verdict left waiting stops rx
// until the receiver takes it.
// Reset clears the line state and the verdict register and restores the
// register to its default.
// ----------------------------------------------------------------------------
module telemetry_line_validator_top import tlv_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  tlv_byte_if.sink              rx,
  tlv_line_if.source            line
);

  logic [SEPX_W-1:0] expected_separators;

  tlv_cfg_regs u_cfg (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .expected_separators (expected_separators)
  );

  tlv_line_tracker #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_tracker (
    .clk                 (clk),
    .rst                 (rst),
    .expected_separators (expected_separators),
    .rx                  (rx),
    .line                (line)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Line validator test: serial bytes go in through the rx channel and each
// line verdict is checked against a per-byte trim and validity model. A
// short directed set covers the corner cases. Random lines follow, mostly
// well formed around the separator setting, with some noise mixed in. The
// separator register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  import tlv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 90;
  localparam int DRAIN_CYCLES   = 4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_EXPECTED_SEP = CFG_ADDR_W'(4 * REG_EXPECTED_SEP);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED     = CFG_ADDR_W'(4);

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] off;
    logic [LENGTH_W-1:0] len;
    logic [SEPCNT_W-1:0] seps;
  } verdict_t;

  class line_judge;
    logic [SEPX_W-1:0] want_seps;
    int unsigned pos, start_idx, kept_end, tail_run, semis;
    bit started, tainted;
    verdict_t verdicts_due[$];
    int unsigned errors, lines, ok_lines, taken;

    function new();
      want_seps = EXPECTED_SEP_RESET;
      clear_line();
    endfunction

    function void clear_line();
      pos = 0;
      started = 0;
      start_idx = 0;
      kept_end = 0;
      tail_run = 0;
      semis = 0;
      tainted = 0;
    endfunction

    function void take_byte(input logic [BYTE_W-1:0] b);
      int unsigned at, len, off;
      bit blank, allowed;
      verdict_t v;
      at = pos;
      taken++;
      blank = (b <= CHAR_SPACE) || (b >= CHAR_HIGH);
      allowed = ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) || (b == CHAR_SEMI) ||
                (b == CHAR_DOT) || (b == CHAR_MINUS);
      if (!started && !(blank || (b == CHAR_LT))) begin
        started = 1;
        start_idx = at;
        kept_end = at;
        tail_run = 0;
      end
      if (started && at >= start_idx) begin
        if (blank || (b == CHAR_GT)) begin
          tail_run++;
        end else begin
          // a kept byte turns any pending tail into interior junk
          if (tail_run != 0 || !allowed) tainted = 1;
          if (b == CHAR_SEMI) semis++;
          kept_end = at + 1;
          tail_run = 0;
        end
      end
      pos = at + 1;
      if (pos < LINE_BUFFER_BYTES_DEF && b != CHAR_LF && b != CHAR_CR) return;
      len = 0;
      off = 0;
      if (started && kept_end > start_idx) begin
        len = kept_end - start_idx;
        off = start_idx;
      end
      v.ok   = (len > 0) && !tainted && (semis == want_seps);
      v.off  = OFFSET_W'(off);
      v.len  = LENGTH_W'(len);
      v.seps = SEPCNT_W'(len > 0 ? semis : 0);
      verdicts_due.push_back(v);
      lines++;
      if (v.ok) ok_lines++;
      clear_line();
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict beat with no line end pending: ok=%0d offset=%0d length=%0d seps=%0d",
               got.ok, got.off, got.len, got.seps);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got.ok !== want.ok) begin
        $error("line_ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.off !== want.off) begin
        $error("start_offset: expected %0d, got %0d", want.off, got.off);
        errors++;
      end
      if (got.len !== want.len) begin
        $error("trimmed_length: expected %0d, got %0d", want.len, got.len);
        errors++;
      end
      if (got.seps !== want.seps) begin
        $error("separator_count: expected %0d, got %0d", want.seps, got.seps);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  tlv_byte_if rx_if();
  tlv_line_if line_if();

  line_judge judge = new();
  bit steady = 0;
  int unsigned idle_cycles;
  int unsigned reg_writes;

  telemetry_line_validator_top uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_if),
    .line    (line_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // verdict receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      line_if.ready <= 1'b0;
    end else begin
      if (line_if.valid && line_if.ready)
        judge.check_verdict({line_if.line_ok, line_if.start_offset,
                             line_if.trimmed_length, line_if.separator_count});
      line_if.ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((rx_if.valid && rx_if.ready) || (line_if.valid && line_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("telemetry_line_validator_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!steady && $urandom_range(99) < 23) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    judge.take_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // drop valid and hold until every verdict is in and the pipe is quiet
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (judge.verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic byte_q_t compose_line(input int unsigned seps);
    byte_q_t q;
    int unsigned kind, semis, r;
    bit crowded;
    kind = $urandom_range(99);
    crowded = (seps > 20);
    if (kind < 10) begin
      repeat ($urandom_range(70, 1)) q.push_back(BYTE_W'($urandom));
      return q;
    end
    semis = seps;
    if (kind < 15) semis = semis + 1;
    else if (kind < 20 && semis > 0) semis = semis - 1;
    if (!crowded) begin
      repeat ($urandom_range(3)) begin
        case ($urandom_range(2))
          0:       q.push_back(BYTE_W'($urandom_range(CHAR_SPACE)));
          1:       q.push_back(CHAR_LT);
          default: q.push_back(BYTE_W'($urandom_range(8'hFF, CHAR_HIGH)));
        endcase
      end
    end
    for (int i = 0; i <= semis; i++) begin
      if (i > 0) q.push_back(CHAR_SEMI);
      repeat (crowded ? int'($urandom_range(9) == 0) : int'($urandom_range(3))) begin
        r = $urandom_range(11);
        q.push_back(r < 10 ? BYTE_W'(CHAR_ZERO + r) : (r == 10 ? CHAR_DOT : CHAR_MINUS));
      end
    end
    if (!crowded) begin
      repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0:       q.push_back(CHAR_SPACE);
          1:       q.push_back(CHAR_GT);
          2:       q.push_back(BYTE_W'($urandom_range(8'h1F)));
          default: q.push_back(BYTE_W'($urandom_range(8'hFF, CHAR_HIGH)));
        endcase
      end
    end
    if (kind >= 20 && kind < 35 && q.size() > 0)
      q[$urandom_range(q.size() - 1)] = BYTE_W'($urandom);
    // blank or '>' inside the body: tail bytes that become interior
    if (kind >= 35 && kind < 42 && q.size() > 2)
      q.insert($urandom_range(q.size() - 2, 1), $urandom_range(1) ? CHAR_SPACE : CHAR_GT);
    if (q.size() < LINE_BUFFER_BYTES_DEF)
      q.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
    return q;
  endfunction

  initial begin
    int unsigned plan[8];
    int unsigned phase_bytes;
    byte_q_t q;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at the reset separator count
    send_byte(CHAR_LF);
    send_text("<1;2;3;4>");
    send_byte(CHAR_LF);
    send_text("1 2");
    send_byte(CHAR_CR);
    send_byte(8'hFF);
    send_text("a");
    send_byte(8'h00);
    send_byte(CHAR_CR);
    send_text(">");
    send_byte(CHAR_LF);
    send_text(".-");
    send_byte(CHAR_CR);

    plan = '{0, 63, 1, 2, 0, 3, 5, 0};
    plan[4] = $urandom_range(63);
    plan[7] = $urandom_range(10);
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 4) write_reg(ADDR_UNMAPPED, $urandom);
      write_reg(ADDR_EXPECTED_SEP, ($urandom & ~32'h3F) | plan[p]);
      judge.want_seps = SEPX_W'(plan[p]);
      steady = (p == 2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        q = compose_line(plan[p]);
        foreach (q[i]) send_byte(q[i]);
        phase_bytes += q.size();
      end
    end
    steady = 0;

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes over %0d register writes; %0d lines ended, %0d of them accepted.",
             judge.taken, reg_writes, judge.lines, judge.ok_lines);
    if (judge.errors == 0) begin
      $display("telemetry_line_validator_top test passed");
    end else begin
      $display("telemetry_line_validator_top test failed");
    end
    $finish;
  end

endmodule
